// ===== rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready queue: field widths,
// opcodes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    // Fixed transaction field widths
    localparam int TASK_W = 6;
    localparam int PRIO_W = 5;

    // Opcodes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ_LINK,
        ST_DEQ_LOOK,
        ST_DEQ_LINK
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic in_ready;      // request channel may accept
        logic enq_first;     // enqueue into empty level: write head/tail, set bit
        logic enq_read_tail; // enqueue into busy level: read its tail
        logic enq_link;      // link new task behind old tail, update tail
        logic deq_start;     // read head/tail of the top level
        logic deq_emit;      // load response, clear bit or fetch link
        logic deq_head_wr;   // write fetched link as new head
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;   // request pending
        logic is_deq;     // pending request is a dequeue
        logic enq_ok;     // enqueue task and level in range
        logic level_busy; // target level already holds tasks
        logic deq_hit;    // captured dequeue found a non-empty level
        logic same;       // head equals tail: level empties on dequeue
        logic out_free;   // response register can take a new transaction
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/prq_if.sv =====
// ----------------------------------------------------------------------------
// prq_if
// Request and response channel interfaces (valid/ready handshake).
// ----------------------------------------------------------------------------
`default_nettype none

interface prq_req_if;
    import prq_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, output opcode, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input opcode, input task_id, input priority_req,
                    output ready);
endinterface

interface prq_rsp_if;
    import prq_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [TASK_W-1:0] next_task;

    modport source (output valid, output found, output next_task, input ready);
    modport sink   (input valid, input found, input next_task, output ready);
endinterface

`default_nettype wire

// ===== rtl/prq_ram.sv =====
// ----------------------------------------------------------------------------
// prq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port (old data on same-address write)
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prq_ctrl.sv =====
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencing state machine: one request at a time through the table
// read/write steps of enqueue and dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire prq_pkg::status_t status,
    output      prq_pkg::cmd_t    cmd
);
    import prq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    if (status.is_deq)
                    begin
                        state_next = ST_DEQ_LOOK;
                    end
                    else if (status.enq_ok && status.level_busy)
                    begin
                        state_next = ST_ENQ_LINK;
                    end
                end
            end
            ST_ENQ_LINK:
            begin
                state_next = ST_IDLE;
            end
            ST_DEQ_LOOK:
            begin
                if (status.out_free)
                begin
                    state_next = (status.deq_hit && !status.same) ? ST_DEQ_LINK : ST_IDLE;
                end
            end
            ST_DEQ_LINK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready      = 1'b1;
                cmd.deq_start     = status.in_valid && status.is_deq;
                cmd.enq_first     = status.in_valid && !status.is_deq && status.enq_ok
                                    && !status.level_busy;
                cmd.enq_read_tail = status.in_valid && !status.is_deq && status.enq_ok
                                    && status.level_busy;
            end
            ST_ENQ_LINK:
            begin
                cmd.enq_link = 1'b1;
            end
            ST_DEQ_LOOK:
            begin
                cmd.deq_emit = status.out_free;
            end
            ST_DEQ_LINK:
            begin
                cmd.deq_head_wr = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/prq_datapath.sv =====
// ----------------------------------------------------------------------------
// prq_datapath
// Level bitmap, priority encoder, head/tail/link tables and the response
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_datapath #(
    parameter int NUM_LEVELS = 32,
    parameter int NUM_TASKS  = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    prq_req_if.sink               req,
    prq_rsp_if.source             rsp,
    input  wire prq_pkg::cmd_t    cmd,
    output      prq_pkg::status_t status
);
    import prq_pkg::*;

    localparam int LVL_AW  = $clog2(NUM_LEVELS);
    localparam int TASK_AW = $clog2(NUM_TASKS);

    // Control state
    logic [NUM_LEVELS-1:0] map_reg;
    logic                  out_valid_reg;
    // Payload state
    logic [LVL_AW-1:0]     lvl_reg;
    logic [TASK_W-1:0]     task_reg;
    logic                  hit_reg;
    logic                  found_reg;
    logic [TASK_W-1:0]     next_task_reg;

    // Request decode
    logic [31:0]       prio_wide;
    logic [31:0]       task_wide;
    logic [LVL_AW-1:0] req_lvl;
    logic              enq_ok;
    logic              accept;

    assign prio_wide = 32'(req.priority_req);
    assign task_wide = 32'(req.task_id);
    assign req_lvl   = prio_wide[LVL_AW-1:0];
    assign enq_ok    = (prio_wide < 32'(NUM_LEVELS)) && (task_wide < 32'(NUM_TASKS));
    assign accept    = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;

    // Priority encoder: lowest set bit is the highest priority level
    logic [LVL_AW-1:0] top_lvl;
    always_comb
    begin
        top_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                top_lvl = LVL_AW'(i);
            end
        end
    end

    // Table ports
    logic [TASK_W-1:0]  head_rdata;
    logic [TASK_W-1:0]  tail_rdata;
    logic [TASK_W-1:0]  link_rdata;
    logic               head_we;
    logic [LVL_AW-1:0]  head_waddr;
    logic [TASK_W-1:0]  head_wdata;
    logic               tail_we;
    logic [LVL_AW-1:0]  tail_waddr;
    logic [TASK_W-1:0]  tail_wdata;
    logic [LVL_AW-1:0]  tail_raddr;
    logic               link_re;
    logic [31:0]        link_waddr_wide;
    logic [31:0]        link_raddr_wide;

    assign head_we    = cmd.enq_first || cmd.deq_head_wr;
    assign head_waddr = cmd.deq_head_wr ? lvl_reg : req_lvl;
    assign head_wdata = cmd.deq_head_wr ? link_rdata : req.task_id;

    assign tail_we    = cmd.enq_first || cmd.enq_link;
    assign tail_waddr = cmd.enq_link ? lvl_reg : req_lvl;
    assign tail_wdata = cmd.enq_link ? task_reg : req.task_id;
    assign tail_raddr = (req.opcode == OP_DEQUEUE) ? top_lvl : req_lvl;

    assign link_re         = cmd.deq_emit && hit_reg && (head_rdata != tail_rdata);
    assign link_waddr_wide = 32'(tail_rdata);
    assign link_raddr_wide = 32'(head_rdata);

    prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (cmd.deq_start),
        .raddr (top_lvl),
        .rdata (head_rdata)
    );

    prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_tail_ram (
        .clk   (clk),
        .we    (tail_we),
        .waddr (tail_waddr),
        .wdata (tail_wdata),
        .re    (cmd.deq_start || cmd.enq_read_tail),
        .raddr (tail_raddr),
        .rdata (tail_rdata)
    );

    prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_link_ram (
        .clk   (clk),
        .we    (cmd.enq_link),
        .waddr (link_waddr_wide[TASK_AW-1:0]),
        .wdata (task_reg),
        .re    (link_re),
        .raddr (link_raddr_wide[TASK_AW-1:0]),
        .rdata (link_rdata)
    );

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            task_reg <= req.task_id;
            lvl_reg  <= (req.opcode == OP_DEQUEUE) ? top_lvl : req_lvl;
            hit_reg  <= (map_reg != '0);
        end
    end

    // Level bitmap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            if (cmd.enq_first)
            begin
                map_reg[req_lvl] <= 1'b1;
            end
            else if (cmd.deq_emit && hit_reg && (head_rdata == tail_rdata))
            begin
                map_reg[lvl_reg] <= 1'b0;
            end
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.deq_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deq_emit)
        begin
            found_reg     <= hit_reg;
            next_task_reg <= hit_reg ? head_rdata : '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = found_reg;
    assign rsp.next_task = next_task_reg;

    // Status to controller
    always_comb
    begin
        status.in_valid   = req.valid;
        status.is_deq     = (req.opcode == OP_DEQUEUE);
        status.enq_ok     = enq_ok;
        status.level_busy = map_reg[req_lvl];
        status.deq_hit    = hit_reg;
        status.same       = (head_rdata == tail_rdata);
        status.out_free   = !out_valid_reg || rsp.ready;
    end

endmodule

`default_nettype wire

// ===== rtl/priority_ready_queue_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_core
// Bitmap-indexed ready queue with one linked FIFO per priority level.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time. An enqueue of a task into an
// empty level (or an out-of-range one, which is dropped) completes as it is
// accepted; into a level that already holds tasks it first reads the level's
// tail, then writes the link and new tail. A dequeue reads the head/tail,
// then emits the response and, if the level keeps tasks, writes the new head;
// the head/tail read and then the link read each pass through a registered
// RAM port before that write. A dequeue also waits while the previous response
// transaction is still held. Level 0 is the highest priority; a dequeue on an
// empty queue returns found = 0 and next_task = 0. A task must not be enqueued
// while it is already queued. The tables are not cleared after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_core #(
    parameter int NUM_LEVELS = 32,
    parameter int NUM_TASKS  = 64
) (
    input wire logic  clk,
    input wire logic  rst_n,
    prq_req_if.sink   req,
    prq_rsp_if.source rsp
);
    import prq_pkg::*;

    cmd_t    cmd;
    status_t status;

    prq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    prq_datapath #(
        .NUM_LEVELS (NUM_LEVELS),
        .NUM_TASKS  (NUM_TASKS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire
